// File: rtl/core/mdmq_pkg.sv
// Shared types and constants for the multi-discipline message queue.
`timescale 1ns / 1ps
package mdmq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 16;
  localparam int PRI_BITS_DEF    = 8;

  localparam logic [1:0] DISC_FIFO = 2'd0;
  localparam logic [1:0] DISC_LIFO = 2'd1;
  localparam logic [1:0] DISC_RAND = 2'd2;
  localparam logic [1:0] DISC_PRIO = 2'd3;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [2:0] OVR_MAX = 3'd4;
  localparam logic [2:0] OVR_NONE = 3'd0;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_NOP  = 2'd2;

  typedef struct packed {
    logic        op;
    logic [15:0] message_in;
    logic [7:0]  priority_in;
    logic [2:0]  discipline_override;
    logic [15:0] random_value;
  } mdmq_in_t;

  typedef struct packed {
    logic        pop_valid;
    logic [15:0] message_out;
    logic        was_empty;
    logic        overflow;
  } mdmq_out_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  disc;
    logic [15:0] msg;
    logic [7:0]  pri;
    logic [15:0] rnd;
  } mdmq_cmd_t;

endpackage

// File: rtl/core/mdmq_front.sv
// Front end: classifies incoming transfers and buffers them as commands.
`timescale 1ns / 1ps
module mdmq_front import mdmq_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  mdmq_in_t   in_data,
  input  logic [1:0] default_disc,
  output logic       cmd_valid,
  output mdmq_cmd_t  cmd,
  input  logic       cmd_take
);

  mdmq_cmd_t  q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  mdmq_cmd_t  cls;
  logic       wr, rd;

  always_comb begin
    cls.msg  = in_data.message_in;
    cls.pri  = in_data.priority_in;
    cls.rnd  = in_data.random_value;
    cls.kind = KIND_PUSH;
    cls.disc = default_disc;
    if (in_data.op == OP_POP) begin
      if (in_data.discipline_override > OVR_MAX) begin
        cls.kind = KIND_NOP;
      end else begin
        cls.kind = KIND_POP;
        if (in_data.discipline_override != OVR_NONE) begin
          cls.disc = 2'(in_data.discipline_override - 3'd1);
        end
      end
    end
  end

  assign full      = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign wr        = push && !full;
  assign rd        = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (wr) begin
      q_r[wp_r] <= cls;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// File: rtl/core/mdmq_back.sv
// Back end: entry store, discipline selection, compaction and result buffer.
`timescale 1ns / 1ps
module mdmq_back import mdmq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int PRI_BITS    = PRI_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  mdmq_cmd_t cmd,
  output logic      cmd_take,
  output logic      empty,
  input  logic      pop,
  output mdmq_out_t out_data
);

  localparam int MSG_W = (ID_BITS < 16) ? ID_BITS : 16;
  localparam int PRI_W = (PRI_BITS < 8) ? PRI_BITS : 8;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_RAND   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_REMOVE = 2'd3;

  logic [MSG_W-1:0]    msg_r [QUEUE_DEPTH];
  logic [PRI_W-1:0]    pri_r [QUEUE_DEPTH];
  logic [CNT_W-1:0]    count_r;
  logic [1:0]          state_r;
  logic [IDX_W-1:0]    idx_r;
  logic [CNT_W-1:0]    scan_r;
  logic [PRI_W-1:0]    best_r;
  logic [CNT_W+15:0]   prod_r;
  logic [CNT_W-1:0]    rand_hi;
  logic [PRI_W-1:0]    scan_pri;

  mdmq_out_t  ofifo_r [2];
  logic       owp_r, orp_r;
  logic [1:0] ocnt_r;
  logic       res_we, res_rd;
  mdmq_out_t  res;

  assign cmd_take = (state_r == S_IDLE) && cmd_valid && (ocnt_r != 2'd2);
  assign rand_hi  = prod_r[CNT_W+15:16];
  assign scan_pri = pri_r[scan_r[IDX_W-1:0]];

  always_comb begin
    res_we = 1'b0;
    res    = '0;
    if (cmd_take) begin
      if (cmd.kind == KIND_PUSH) begin
        res_we        = 1'b1;
        res.overflow  = (count_r == DEPTH_C);
        res.was_empty = (count_r == '0);
      end else if (cmd.kind != KIND_POP || count_r == '0) begin
        res_we = 1'b1;
      end
    end else if (state_r == S_REMOVE) begin
      res_we          = 1'b1;
      res.pop_valid   = 1'b1;
      res.message_out = 16'(msg_r[idx_r]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take && cmd.kind == KIND_PUSH && count_r != DEPTH_C) begin
      msg_r[count_r[IDX_W-1:0]] <= cmd.msg[MSG_W-1:0];
      pri_r[count_r[IDX_W-1:0]] <= cmd.pri[PRI_W-1:0];
    end
    if (state_r == S_REMOVE) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        if (IDX_W'(i) >= idx_r) begin
          msg_r[i] <= msg_r[i+1];
          pri_r[i] <= pri_r[i+1];
        end
      end
    end
    if (cmd_take) begin
      prod_r <= (CNT_W+16)'(count_r) * (CNT_W+16)'(cmd.rnd);
      best_r <= pri_r[0];
      scan_r <= CNT_W'(1);
      unique case (cmd.disc)
        DISC_LIFO: idx_r <= IDX_W'(count_r - CNT_W'(1));
        default:   idx_r <= '0;
      endcase
    end
    if (state_r == S_RAND) begin
      idx_r <= (rand_hi >= count_r) ? IDX_W'(count_r - CNT_W'(1)) : IDX_W'(rand_hi);
    end
    if (state_r == S_SCAN && scan_r < count_r) begin
      scan_r <= scan_r + CNT_W'(1);
      if (scan_pri > best_r) begin
        best_r <= scan_pri;
        idx_r  <= scan_r[IDX_W-1:0];
      end
    end
    if (res_we) begin
      ofifo_r[owp_r] <= res;
    end
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      owp_r   <= 1'b0;
      orp_r   <= 1'b0;
      ocnt_r  <= 2'd0;
    end else begin
      if (res_we) owp_r <= ~owp_r;
      if (res_rd) orp_r <= ~orp_r;
      ocnt_r <= ocnt_r + {1'b0, res_we} - {1'b0, res_rd};
      unique case (state_r)
        S_IDLE: begin
          if (cmd_take) begin
            if (cmd.kind == KIND_PUSH) begin
              if (count_r != DEPTH_C) count_r <= count_r + CNT_W'(1);
            end else if (cmd.kind == KIND_POP && count_r != '0) begin
              unique case (cmd.disc)
                DISC_RAND: state_r <= S_RAND;
                DISC_PRIO: state_r <= S_SCAN;
                default:   state_r <= S_REMOVE;
              endcase
            end
          end
        end
        S_RAND: state_r <= S_REMOVE;
        S_SCAN: begin
          if (scan_r >= count_r) state_r <= S_REMOVE;
        end
        S_REMOVE: begin
          count_r <= count_r - CNT_W'(1);
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign empty    = (ocnt_r == 2'd0);
  assign res_rd   = pop && !empty;
  assign out_data = ofifo_r[orp_r];

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above depth");
  a_remove_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REMOVE |-> count_r != '0) else $error("removal from empty store");
  a_remove_index: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_REMOVE |-> CNT_W'(idx_r) < count_r) else $error("removal index out of range");
  a_ofifo_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_we |-> (ocnt_r != 2'd2 || res_rd)) else $error("result buffer overrun");

endmodule

// File: rtl/core/multi_discipline_message_queue.sv
// Top level of the multi-discipline message queue.
// Input channel: in_data carries a push or pop request; it transfers on a clock edge
// with push high and full low. A command buffer of two entries sits behind it.
// Result channel: out_data holds the oldest result while empty is low; it transfers
// on a clock edge with pop high. Every request gives exactly one result.
// Config: cfg_we writes cfg_data as the default pop discipline (fifo, lifo,
// random, priority); write it only while the block is idle.
// Back end: a push, an invalid pop or a pop of an empty queue is resolved as
// the back end takes it; fifo and lifo pops then go to removal, random pops
// multiply on take, then clamp before removal, and priority pops first run the
// one-entry-per-cycle priority scan. Removal compacts the store. A request is
// registered in the command buffer, and its result then in the result buffer.
// Reset (rst_n low, synchronous) empties the store and both buffers and sets
// the default discipline to fifo. When the receiver stalls, two results wait;
// then the back end stops and the command buffer fills and raises full.
`timescale 1ns / 1ps
module multi_discipline_message_queue import mdmq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int PRI_BITS    = PRI_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  mdmq_in_t   in_data,
  output logic       empty,
  input  logic       pop,
  output mdmq_out_t  out_data,
  input  logic       cfg_we,
  input  logic [1:0] cfg_data
);

  logic [1:0] default_disc_r;
  logic       cmd_valid, cmd_take;
  mdmq_cmd_t  cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_disc_r <= DISC_FIFO;
    end else if (cfg_we) begin
      default_disc_r <= cfg_data;
    end
  end

  mdmq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_data      (in_data),
    .default_disc (default_disc_r),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_take     (cmd_take)
  );

  mdmq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .PRI_BITS    (PRI_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data)
  );

endmodule

// File: verif/testbench.sv
// Testbench for the multi-discipline message queue: predicted pop and push outcomes per transfer.
`timescale 1ns / 1ps
module testbench;
  import mdmq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      full;
  mdmq_in_t  in_data = '0;
  logic      empty;
  logic      pop = 1'b0;
  mdmq_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0] cfg_data = DISC_FIFO;

  multi_discipline_message_queue i_dut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [15:0] q_msg [16];
  logic [7:0]  q_pri [16];
  int          q_count = 0;
  logic [1:0]  dflt_disc = DISC_FIFO;
  mdmq_out_t   exp_ring [64];
  int          exp_wr = 0;
  int          exp_rd = 0;
  int          errors = 0;
  int          n_items = 0;
  int          n_pops_valid = 0;
  int          n_overflows = 0;
  int          idle_pct = 20;

  function automatic mdmq_out_t queue_outcome(mdmq_in_t it);
    mdmq_out_t r;
    logic [1:0] disc;
    int idx;
    logic [7:0] best;
    r = '0;
    if (it.op == OP_PUSH) begin
      if (q_count >= 16) r.overflow = 1'b1;
      else begin
        r.was_empty = (q_count == 0);
        q_msg[q_count] = it.message_in;
        q_pri[q_count] = it.priority_in;
        q_count++;
      end
      return r;
    end
    if (q_count == 0 || it.discipline_override > OVR_MAX) return r;
    disc = (it.discipline_override == OVR_NONE) ? dflt_disc : 2'(it.discipline_override - 1);
    idx = 0;
    case (disc)
      DISC_FIFO: idx = 0;
      DISC_LIFO: idx = q_count - 1;
      DISC_RAND: begin
        idx = (q_count * int'(it.random_value)) >> 16;
        if (idx >= q_count) idx = q_count - 1;
      end
      default: begin
        best = q_pri[0];
        for (int i = 1; i < q_count; i++)
          if (q_pri[i] > best) begin
            best = q_pri[i];
            idx = i;
          end
      end
    endcase
    r.pop_valid = 1'b1;
    r.message_out = q_msg[idx];
    for (int i = idx; i + 1 < q_count; i++) begin
      q_msg[i] = q_msg[i + 1];
      q_pri[i] = q_pri[i + 1];
    end
    q_count--;
    return r;
  endfunction

  task automatic send_item(mdmq_in_t it);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (full);
    exp_ring[exp_wr % 64] = queue_outcome(it);
    exp_wr++;
    n_items++;
    @(negedge clk);
  endtask

  always @(negedge clk) pop <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (exp_wr == exp_rd) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        mdmq_out_t e;
        e = exp_ring[exp_rd % 64];
        exp_rd++;
        if (out_data.pop_valid !== e.pop_valid) begin
          $error("pop_valid exp %0d got %0d", e.pop_valid, out_data.pop_valid); errors++;
        end
        if (out_data.message_out !== e.message_out) begin
          $error("message_out exp %0h got %0h", e.message_out, out_data.message_out); errors++;
        end
        if (out_data.was_empty !== e.was_empty) begin
          $error("was_empty exp %0d got %0d", e.was_empty, out_data.was_empty); errors++;
        end
        if (out_data.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, out_data.overflow); errors++;
        end
        if (e.pop_valid) n_pops_valid++;
        if (e.overflow) n_overflows++;
      end
    end
  end

  function automatic mdmq_in_t mk(logic op, logic [15:0] m, logic [7:0] p,
                                  logic [2:0] o, logic [15:0] r);
    mdmq_in_t it;
    it.op = op; it.message_in = m; it.priority_in = p;
    it.discipline_override = o; it.random_value = r;
    return it;
  endfunction

  task automatic drain();
    push <= 1'b0;
    while (exp_wr != exp_rd) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_default(logic [1:0] d);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= d;
    @(negedge clk);
    cfg_we <= 1'b0;
    dflt_disc = d;
  endtask

  task automatic test_directed();
    send_item(mk(OP_POP, 16'hFFFF, 8'hFF, OVR_NONE, 16'hFFFF));
    send_item(mk(OP_PUSH, 16'h0000, 8'h00, 3'd7, 16'h0000));
    send_item(mk(OP_PUSH, 16'hFFFF, 8'hFF, OVR_NONE, 16'hFFFF));
    send_item(mk(OP_PUSH, 16'h1234, 8'hFF, OVR_NONE, 16'h0));
    send_item(mk(OP_PUSH, 16'h5678, 8'h10, OVR_NONE, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd5, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd7, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd4, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd3, 16'hFFFF));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd2, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd1, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, OVR_NONE, 16'h0));
    for (int i = 0; i < 17; i++)
      send_item(mk(OP_PUSH, 16'(i * 4099), 8'(i % 3), OVR_NONE, 16'h0));
    send_item(mk(OP_POP, 16'h0, 8'h0, 3'd3, 16'h0));
  endtask

  task automatic test_random(int n, int push_pct);
    mdmq_in_t it;
    for (int i = 0; i < n; i++) begin
      it = mk(OP_POP, 16'($urandom), 8'($urandom), 3'($urandom_range(4)), 16'($urandom));
      if ($urandom_range(99) < push_pct) it.op = OP_PUSH;
      if ($urandom_range(19) == 0) it.discipline_override = 3'($urandom_range(7, 5));
      if ($urandom_range(3) == 0) it.priority_in = 8'($urandom_range(3));
      send_item(it);
    end
  endtask

  task automatic test_disciplines();
    for (int d = 0; d < 4; d++) begin
      write_default(2'(d));
      test_random(200, 55);
      test_random(150, 40);
    end
  endtask

  task automatic test_no_idle();
    idle_pct = 0;
    test_random(300, 50);
    idle_pct = 20;
    write_default(DISC_PRIO);
    test_random(200, 70);
    write_default(DISC_RAND);
    test_random(100, 30);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_disciplines();
    test_no_idle();
    drain();
    $display("%0d requests sent over all four defaults and overrides;", n_items);
    $display("%0d pops served, %0d overflows", n_pops_valid, n_overflows);
    if (errors == 0) $display("multi_discipline_message_queue verification clean");
    else $display("multi_discipline_message_queue verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("multi_discipline_message_queue verification failed");
    $finish;
  end
endmodule
